[rtl/cbts_pkg.sv]
// shared types, layout table and constants for the can bit timing search
`timescale 1ns / 1ps

package cbts_pkg;

  localparam int LAYOUT_COUNT = 21;
  localparam int IDX_W        = 5;
  localparam int CLOCK_W      = 32;
  localparam int RATE_W       = 20;
  localparam int QUANTA_W     = 5;
  localparam int SEG1_W       = 5;
  localparam int SEG2_W       = 4;
  localparam int PRESC_OUT_W  = 11;
  localparam int JUMP_W       = 3;
  localparam logic [SEG2_W-1:0] JUMP_LIMIT = 4'd4;

  typedef struct packed {
    logic [QUANTA_W-1:0] quanta;
    logic [SEG1_W-1:0]   seg1;
    logic [SEG2_W-1:0]   seg2;
  } layout_t;

  localparam layout_t LAYOUTS [LAYOUT_COUNT] = '{
    '{5'd23, 5'd16, 4'd6}, '{5'd22, 5'd16, 4'd5}, '{5'd21, 5'd15, 4'd5},
    '{5'd20, 5'd14, 4'd5}, '{5'd19, 5'd13, 4'd5}, '{5'd18, 5'd13, 4'd4},
    '{5'd17, 5'd12, 4'd4}, '{5'd16, 5'd11, 4'd4}, '{5'd15, 5'd10, 4'd4},
    '{5'd14, 5'd10, 4'd3}, '{5'd13, 5'd9,  4'd3}, '{5'd12, 5'd8,  4'd3},
    '{5'd11, 5'd7,  4'd3}, '{5'd10, 5'd7,  4'd2}, '{5'd9,  5'd6,  4'd2},
    '{5'd8,  5'd5,  4'd2}, '{5'd7,  5'd4,  4'd2}, '{5'd6,  5'd4,  4'd1},
    '{5'd5,  5'd3,  4'd1}, '{5'd4,  5'd3,  4'd1}, '{5'd3,  5'd2,  4'd1}
  };

  // candidate issued to the test unit
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } cand_ctl_t;

  // outcome of one candidate test
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic             last;
    logic [IDX_W-1:0] idx;
  } cand_res_t;

endpackage

[rtl/cbts_test_unit.sv]
// shared multiply and window compare unit that tests one candidate per cycle
`timescale 1ns / 1ps

module cbts_test_unit #(
  parameter int PW = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cbts_pkg::CLOCK_W-1:0]  clock_hz,
  input  logic [cbts_pkg::RATE_W+PW-1:0] rate_x_p,
  input  logic [PW-1:0]                 presc,
  input  cbts_pkg::cand_ctl_t           cand,
  output cbts_pkg::cand_res_t           res,
  output logic [PW-1:0]                 res_presc
);
  import cbts_pkg::*;

  localparam int RPW = RATE_W + PW;
  localparam int PRW = RPW + QUANTA_W;
  localparam int MW  = PW + QUANTA_W;
  localparam int CW  = (PRW > CLOCK_W) ? PRW : CLOCK_W;

  logic [QUANTA_W-1:0] quanta;
  logic [PRW-1:0]      prod_r, prod_nxt;
  logic [MW-1:0]       span_r, span_nxt;
  cand_ctl_t           ctl_r;
  logic [PW-1:0]       presc_r;
  logic [CW-1:0]       clock_ext, prod_ext, span_ext, diff;

  assign quanta   = LAYOUTS[cand.idx].quanta;
  assign prod_nxt = PRW'(rate_x_p) * PRW'(quanta);
  assign span_nxt = MW'(presc) * MW'(quanta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= cand.vld;
    end
    ctl_r.last <= cand.last;
    ctl_r.idx  <= cand.idx;
    prod_r     <= prod_nxt;
    span_r     <= span_nxt;
    presc_r    <= presc;
  end

  // floor(clock / span) == rate  <=>  rate*span <= clock < rate*span + span
  assign clock_ext = CW'(clock_hz);
  assign prod_ext  = CW'(prod_r);
  assign span_ext  = CW'(span_r);
  assign diff      = clock_ext - prod_ext;

  assign res.vld   = ctl_r.vld;
  assign res.hit   = (prod_ext <= clock_ext) && (diff < span_ext);
  assign res.last  = ctl_r.last;
  assign res.idx   = ctl_r.idx;
  assign res_presc = presc_r;

endmodule

[rtl/can_bit_timing_search.sv]
// top level: sequencer that walks prescaler and layout candidates through the test unit
//
//  channel  | handshake            | ports
//  ---------+----------------------+----------------------------------------------
//  request  | start && !busy       | in_clock_hz, in_bit_rate
//  result   | out_strobe, 1 cycle  | out_found, out_prescaler_value, out_segment_one,
//           |                      | out_segment_two, out_quanta_per_bit, out_jump_width
//
// candidate k (k = (prescaler-1)*entries + layout index) is decided once it has passed the
// input registers of the test unit; a request with no match tries all MAX_PRESCALE*entries
// candidates. the test unit decides one candidate per cycle. busy is high from the request
// until the result strobe. reset clears the sequencer and the strobe. the receiver cannot stall
// the result.
`timescale 1ns / 1ps

module can_bit_timing_search #(
  parameter int MAX_PRESCALE  = 1024,
  parameter int TABLE_ENTRIES = 21
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [cbts_pkg::CLOCK_W-1:0]       in_clock_hz,
  input  logic [cbts_pkg::RATE_W-1:0]        in_bit_rate,
  output logic                               out_strobe,
  output logic                               out_found,
  output logic [cbts_pkg::PRESC_OUT_W-1:0]   out_prescaler_value,
  output logic [cbts_pkg::SEG1_W-1:0]        out_segment_one,
  output logic [cbts_pkg::SEG2_W-1:0]        out_segment_two,
  output logic [cbts_pkg::QUANTA_W-1:0]      out_quanta_per_bit,
  output logic [cbts_pkg::JUMP_W-1:0]        out_jump_width
);
  import cbts_pkg::*;

  localparam int PW      = $clog2(MAX_PRESCALE + 1);
  localparam int RPW     = RATE_W + PW;
  localparam int ENTRIES = (TABLE_ENTRIES > LAYOUT_COUNT) ? LAYOUT_COUNT : TABLE_ENTRIES;

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t              state_r;
  logic                issue_on_r;
  logic [PW-1:0]       presc_r;
  logic [IDX_W-1:0]    idx_r;
  logic [RPW-1:0]      rate_x_p_r;
  logic [CLOCK_W-1:0]  clock_r;
  logic [RATE_W-1:0]   rate_r;
  logic                take;
  logic                finish;
  logic                last_idx;
  logic                last_cand;
  cand_ctl_t           cand;
  cand_res_t           res;
  logic [PW-1:0]       res_presc;
  layout_t             hit_layout;

  assign busy      = (state_r != IDLE);
  assign take      = start && !busy;
  assign finish    = (state_r == RUN) && res.vld && (res.hit || res.last);
  assign last_idx  = (idx_r == IDX_W'(ENTRIES - 1));
  assign last_cand = last_idx && (presc_r == PW'(MAX_PRESCALE));

  assign cand.vld  = (state_r == RUN) && issue_on_r && !finish;
  assign cand.last = last_cand;
  assign cand.idx  = idx_r;

  cbts_test_unit #(
    .PW (PW)
  ) u_test (
    .clk       (clk),
    .rst_n     (rst_n),
    .clock_hz  (clock_r),
    .rate_x_p  (rate_x_p_r),
    .presc     (presc_r),
    .cand      (cand),
    .res       (res),
    .res_presc (res_presc)
  );

  assign hit_layout = LAYOUTS[res.idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= IDLE;
      issue_on_r <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (state_r)
        IDLE: begin
          if (take) begin
            state_r    <= RUN;
            issue_on_r <= 1'b1;
          end
        end
        RUN: begin
          if (finish) begin
            state_r    <= IDLE;
            issue_on_r <= 1'b0;
            out_strobe <= 1'b1;
          end else if (cand.vld && last_cand) begin
            issue_on_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= IDLE;
          issue_on_r <= 1'b0;
        end
      endcase
    end
  end

  // candidate walk: layouts inner, prescalers outer, rate*prescaler kept by adding
  always_ff @(posedge clk) begin
    if (take) begin
      clock_r    <= in_clock_hz;
      rate_r     <= in_bit_rate;
      presc_r    <= PW'(1);
      idx_r      <= '0;
      rate_x_p_r <= RPW'(in_bit_rate);
    end else if (cand.vld) begin
      if (last_idx) begin
        idx_r      <= '0;
        presc_r    <= presc_r + PW'(1);
        rate_x_p_r <= rate_x_p_r + RPW'(rate_r);
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (res.hit) begin
        out_found           <= 1'b1;
        out_prescaler_value <= PRESC_OUT_W'(res_presc);
        out_segment_one     <= hit_layout.seg1;
        out_segment_two     <= hit_layout.seg2;
        out_quanta_per_bit  <= hit_layout.quanta;
        out_jump_width      <= (hit_layout.seg2 > JUMP_LIMIT) ? JUMP_W'(JUMP_LIMIT)
                                                              : JUMP_W'(hit_layout.seg2);
      end else begin
        out_found           <= 1'b0;
        out_prescaler_value <= '0;
        out_segment_one     <= '0;
        out_segment_two     <= '0;
        out_quanta_per_bit  <= '0;
        out_jump_width      <= '0;
      end
    end
  end

endmodule

[rtl/cbts_checker.sv]
// port level checks for the can bit timing search, bound to the top level
`timescale 1ns / 1ps

module cbts_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_strobe,
  input logic                               out_found,
  input logic [cbts_pkg::PRESC_OUT_W-1:0]   out_prescaler_value,
  input logic [cbts_pkg::SEG1_W-1:0]        out_segment_one,
  input logic [cbts_pkg::SEG2_W-1:0]        out_segment_two,
  input logic [cbts_pkg::QUANTA_W-1:0]      out_quanta_per_bit,
  input logic [cbts_pkg::JUMP_W-1:0]        out_jump_width
);
  import cbts_pkg::*;

  // a taken request keeps the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  // a result ends the request
  a_idle_on_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && !$past(out_strobe))
    else $error("result shown while busy or twice in a row");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_found |-> out_prescaler_value == '0 && out_segment_one == '0 &&
      out_segment_two == '0 && out_quanta_per_bit == '0 && out_jump_width == '0)
    else $error("fields not cleared on a miss");

  // the prescaler and segment two are nonzero, segment one fits inside the bit and the jump width follows segment two
  a_hit_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_found |-> out_prescaler_value != '0 &&
      out_quanta_per_bit > out_segment_one && out_segment_two != '0 &&
      out_jump_width == ((out_segment_two > JUMP_LIMIT) ? JUMP_W'(JUMP_LIMIT)
                                                        : JUMP_W'(out_segment_two)))
    else $error("inconsistent timing result");

endmodule

bind can_bit_timing_search cbts_checker u_cbts_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_strobe          (out_strobe),
  .out_found           (out_found),
  .out_prescaler_value (out_prescaler_value),
  .out_segment_one     (out_segment_one),
  .out_segment_two     (out_segment_two),
  .out_quanta_per_bit  (out_quanta_per_bit),
  .out_jump_width      (out_jump_width)
);
